FILE: src/arcp_pkg.sv
package arcp_pkg;

    localparam int RATE_W    = 24;
    localparam int CREDIT_W  = 32;
    localparam int ELAPSED_W = 32;
    localparam int CAP_W     = 20;
    localparam int STEP_W    = 16;
    localparam int LEN_W     = 16;
    localparam int OVH_W     = 10;
    localparam int CFG_W     = 24;
    localparam int IDX_W     = 3;
    localparam int CMD_W     = 2;

    // refill = floor(rate * ecap / 1000), split as rate = 1000*rh + rl
    localparam int RH_W      = 15;
    localparam int RL_W      = 10;
    localparam int LO_W      = 30;
    localparam int Q_W       = 21;
    localparam int REFILL_W  = 35;

    localparam int DIV1000_MUL_W = 25;
    localparam int DIV1000_SHIFT = 34;
    localparam logic [DIV1000_MUL_W-1:0] DIV1000_MUL = 25'd17179870;

    // floor(x/1000) = floor(floor(x/8)/125)
    localparam int DIV8_SHIFT    = 3;
    localparam int DIV125_MUL_W  = 28;
    localparam int DIV125_SHIFT  = 34;
    localparam logic [DIV125_MUL_W-1:0] DIV125_MUL = 28'd137438954;

    // floor(rate * 95 / 100)
    localparam int CUT95_MUL_W   = 31;
    localparam int CUT95_SHIFT   = 31;
    localparam logic [CUT95_MUL_W-1:0] CUT95_MUL = 31'd2040109466;

    localparam logic [RATE_W-1:0] KILO = 24'd1000;

    localparam logic [STEP_W-1:0] RATE_STEP_RST       = 16'd16;
    localparam logic [RATE_W-1:0] START_RATE_RST      = 24'd20000;
    localparam logic [CAP_W-1:0]  ELAPSED_CAP_RST     = 20'd20000;
    localparam logic [OVH_W-1:0]  PACKET_OVERHEAD_RST = 10'd100;
    localparam logic [RATE_W-1:0] CUT_FLOOR_RST       = 24'd100;

    localparam logic [RATE_W-1:0]          RATE_MAX   = 24'hFFFFFF;
    localparam logic signed [CREDIT_W-1:0] CREDIT_MAX = 32'sh7FFFFFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_ROUND_START  = 2'd0,
        CMD_PACKET_OFFER = 2'd1,
        CMD_ROUND_END    = 2'd2,
        CMD_REPOSITION   = 2'd3
    } arcp_cmd_t;

    typedef enum logic [IDX_W-1:0] {
        REG_RATE_STEP       = 3'd0,
        REG_START_RATE      = 3'd1,
        REG_ELAPSED_CAP     = 3'd2,
        REG_PACKET_OVERHEAD = 3'd3,
        REG_CUT_FLOOR       = 3'd4
    } arcp_reg_t;

    typedef enum logic [1:0] {
        RF_SPLIT   = 2'd0,
        RF_PARTIAL = 2'd1,
        RF_SUM     = 2'd2,
        RF_DONE    = 2'd3
    } arcp_refill_state_t;

    typedef struct packed {
        logic run;
        logic take;
    } arcp_refill_ctl_t;

endpackage

FILE: src/arcp_item_if.sv
interface arcp_item_if import arcp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [ELAPSED_W-1:0] elapsed;
    logic [LEN_W-1:0]     packet_length;
    logic                 send_ok;
    logic                 moved;
    logic                 backward;

    modport source (
        output valid, command, elapsed, packet_length, send_ok, moved, backward,
        input  ready
    );

    modport sink (
        input  valid, command, elapsed, packet_length, send_ok, moved, backward,
        output ready
    );
endinterface

FILE: src/arcp_result_if.sv
interface arcp_result_if import arcp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       grant;
    logic                       credit_left;
    logic [RATE_W-1:0]          rate_now;
    logic signed [CREDIT_W-1:0] credit_now;

    modport source (
        output valid, grant, credit_left, rate_now, credit_now,
        input  ready
    );

    modport sink (
        input  valid, grant, credit_left, rate_now, credit_now,
        output ready
    );
endinterface

FILE: src/arcp_refill.sv
module arcp_refill import arcp_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  arcp_refill_ctl_t     ctl,
    input  logic [RATE_W-1:0]    rate,
    input  logic [ELAPSED_W-1:0] elapsed,
    input  logic [CAP_W-1:0]     elapsed_cap,
    output logic                 done,
    output logic [REFILL_W-1:0]  refill
);

    localparam int P1_W = RATE_W + DIV1000_MUL_W;
    localparam int X_W  = LO_W - DIV8_SHIFT;
    localparam int P2_W = X_W + DIV125_MUL_W;

    arcp_refill_state_t state_reg, state_next;

    logic [RH_W-1:0]     rh_reg;
    logic [CAP_W-1:0]    ecap_reg;
    logic [REFILL_W-1:0] hi_reg;
    logic [LO_W-1:0]     lo_reg;
    logic [REFILL_W-1:0] refill_reg;

    logic [P1_W-1:0]   prod1;
    logic [RH_W-1:0]   rh_calc;
    logic [CAP_W-1:0]  ecap_calc;
    logic [RATE_W-1:0] rh_kilo;
    logic [RATE_W-1:0] rl_full;
    logic [RL_W-1:0]   rl;
    logic [X_W-1:0]    lo_div8;
    logic [P2_W-1:0]   prod2;
    logic [Q_W-1:0]    q;

    always_comb
    begin
        prod1     = P1_W'(rate) * P1_W'(DIV1000_MUL);
        rh_calc   = prod1[DIV1000_SHIFT +: RH_W];
        ecap_calc = (elapsed > ELAPSED_W'(elapsed_cap)) ? elapsed_cap : elapsed[CAP_W-1:0];
        rh_kilo   = RATE_W'(rh_reg) * KILO;
        rl_full   = rate - rh_kilo;
        rl        = rl_full[RL_W-1:0];
        lo_div8   = lo_reg[LO_W-1:DIV8_SHIFT];
        prod2     = P2_W'(lo_div8) * P2_W'(DIV125_MUL);
        q         = prod2[DIV125_SHIFT +: Q_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RF_SPLIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done       = 1'b0;
        if (!ctl.run)
        begin
            state_next = RF_SPLIT;
        end
        else
        begin
            unique case (state_reg)
                RF_SPLIT:   state_next = RF_PARTIAL;
                RF_PARTIAL: state_next = RF_SUM;
                RF_SUM:     state_next = RF_DONE;
                RF_DONE:
                begin
                    done = 1'b1;
                    if (ctl.take)
                    begin
                        state_next = RF_SPLIT;
                    end
                end
                default:    state_next = RF_SPLIT;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.run)
        begin
            if (state_reg == RF_SPLIT)
            begin
                rh_reg   <= rh_calc;
                ecap_reg <= ecap_calc;
            end
            if (state_reg == RF_PARTIAL)
            begin
                hi_reg <= REFILL_W'(rh_reg) * REFILL_W'(ecap_reg);
                lo_reg <= LO_W'(rl) * LO_W'(ecap_reg);
            end
            if (state_reg == RF_SUM)
            begin
                refill_reg <= hi_reg + REFILL_W'(q);
            end
        end
    end

    assign refill = refill_reg;

endmodule

FILE: src/adaptive_rate_credit_pacer_unit.sv
// Packet offer, round end and reposition go from the input word register to the
// result word register; a round start waits in between for the refill states.
// Throughput: one word per cycle unless results stall; a round start holds the
// input register while the refill multiply and divide-by-1000 chain runs.
// Reset (rst_n, async low): registers to defaults, rate and target to 20000,
// credit 0, granted flag clear, both channels empty.
module adaptive_rate_credit_pacer_unit import arcp_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    arcp_item_if.sink        item,
    arcp_result_if.source    result
);

    localparam int SUM_W  = REFILL_W + 1;
    localparam int RSUM_W = RATE_W + 1;
    localparam int CUT_W  = RATE_W + CUT95_MUL_W;
    localparam logic signed [SUM_W-1:0] CREDIT_MAX_WIDE = SUM_W'(CREDIT_MAX);

    // configuration
    logic [STEP_W-1:0] rate_step_reg;
    logic [CAP_W-1:0]  elapsed_cap_reg;
    logic [OVH_W-1:0]  overhead_reg;
    logic [RATE_W-1:0] cut_floor_reg;

    // input word register
    logic                 item_valid_reg;
    logic [CMD_W-1:0]     cmd_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [LEN_W-1:0]     len_reg;
    logic                 send_ok_reg;
    logic                 moved_reg;
    logic                 backward_reg;

    // pacer state
    logic [RATE_W-1:0]          rate_reg, rate_next;
    logic [RATE_W-1:0]          target_reg, target_next;
    logic signed [CREDIT_W-1:0] credit_reg, credit_next;
    logic                       granted_reg, granted_next;
    logic                       grant_next;

    // result word register
    logic                       res_valid_reg;
    logic                       res_grant_reg;
    logic                       res_left_reg;
    logic [RATE_W-1:0]          res_rate_reg;
    logic signed [CREDIT_W-1:0] res_credit_reg;

    arcp_refill_ctl_t    refill_ctl;
    logic                refill_done;
    logic [REFILL_W-1:0] refill;

    logic out_free;
    logic busy_start;
    logic item_done;
    logic consume;

    logic                       credit_pos;
    logic signed [SUM_W-1:0]    base_wide;
    logic signed [SUM_W-1:0]    sum_wide;
    logic [STEP_W-1:0]          inc;
    logic [RSUM_W-1:0]          rate_sum;
    logic [CUT_W-1:0]           cut_prod;
    logic [RATE_W-1:0]          rate_new;
    logic [RSUM_W-1:0]          avg_sum;

    assign out_free   = !res_valid_reg || result.ready;
    assign busy_start = item_valid_reg && (cmd_reg == CMD_ROUND_START);
    assign item_done  = item_valid_reg && ((cmd_reg != CMD_ROUND_START) || refill_done);
    assign consume    = item_done && out_free;
    assign item.ready = !item_valid_reg || consume;

    assign refill_ctl.run  = busy_start;
    assign refill_ctl.take = out_free;

    arcp_refill u_refill (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (refill_ctl),
        .rate        (rate_reg),
        .elapsed     (elapsed_reg),
        .elapsed_cap (elapsed_cap_reg),
        .done        (refill_done),
        .refill      (refill)
    );

    always_comb
    begin
        credit_pos   = credit_reg > 0;
        base_wide    = credit_pos ? '0 : SUM_W'(credit_reg);
        sum_wide     = base_wide + $signed({1'b0, refill});
        inc          = (rate_reg < target_reg) ? rate_step_reg : (rate_step_reg >> 1);
        rate_sum     = RSUM_W'(rate_reg) + RSUM_W'(inc);
        cut_prod     = CUT_W'(rate_reg) * CUT_W'(CUT95_MUL);
        rate_new     = (backward_reg && (rate_reg > cut_floor_reg))
                     ? cut_prod[CUT95_SHIFT +: RATE_W] : rate_reg;
        avg_sum      = RSUM_W'(rate_reg) + RSUM_W'(rate_new);

        rate_next    = rate_reg;
        target_next  = target_reg;
        credit_next  = credit_reg;
        granted_next = granted_reg;
        grant_next   = 1'b0;

        unique case (cmd_reg)
            CMD_ROUND_START:
            begin
                credit_next  = (sum_wide > CREDIT_MAX_WIDE) ? CREDIT_MAX
                                                            : sum_wide[CREDIT_W-1:0];
                granted_next = 1'b0;
            end
            CMD_PACKET_OFFER:
            begin
                if (credit_pos)
                begin
                    grant_next   = 1'b1;
                    credit_next  = credit_reg
                                 - $signed(CREDIT_W'(len_reg) + CREDIT_W'(overhead_reg));
                    granted_next = 1'b1;
                end
            end
            CMD_ROUND_END:
            begin
                if (send_ok_reg && granted_reg && !credit_pos)
                begin
                    rate_next = rate_sum[RATE_W] ? RATE_MAX : rate_sum[RATE_W-1:0];
                end
                granted_next = 1'b0;
            end
            CMD_REPOSITION:
            begin
                if (moved_reg)
                begin
                    rate_next   = rate_new;
                    target_next = avg_sum[RSUM_W-1:1];
                end
            end
            default:
            begin
                rate_next = rate_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_step_reg   <= RATE_STEP_RST;
            elapsed_cap_reg <= ELAPSED_CAP_RST;
            overhead_reg    <= PACKET_OVERHEAD_RST;
            cut_floor_reg   <= CUT_FLOOR_RST;
            rate_reg        <= START_RATE_RST;
            target_reg      <= START_RATE_RST;
            credit_reg      <= '0;
            granted_reg     <= 1'b0;
            item_valid_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (consume)
            begin
                rate_reg    <= rate_next;
                target_reg  <= target_next;
                credit_reg  <= credit_next;
                granted_reg <= granted_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RATE_STEP:       rate_step_reg   <= cfg_data[STEP_W-1:0];
                    REG_START_RATE:
                    begin
                        rate_reg   <= cfg_data[RATE_W-1:0];
                        target_reg <= cfg_data[RATE_W-1:0];
                    end
                    REG_ELAPSED_CAP:     elapsed_cap_reg <= cfg_data[CAP_W-1:0];
                    REG_PACKET_OVERHEAD: overhead_reg    <= cfg_data[OVH_W-1:0];
                    REG_CUT_FLOOR:       cut_floor_reg   <= cfg_data[RATE_W-1:0];
                    default:             cut_floor_reg   <= cut_floor_reg;
                endcase
            end
            if (item.ready)
            begin
                item_valid_reg <= item.valid;
            end
            if (out_free)
            begin
                res_valid_reg <= consume;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            cmd_reg      <= item.command;
            elapsed_reg  <= item.elapsed;
            len_reg      <= item.packet_length;
            send_ok_reg  <= item.send_ok;
            moved_reg    <= item.moved;
            backward_reg <= item.backward;
        end
        if (consume)
        begin
            res_grant_reg  <= grant_next;
            res_left_reg   <= credit_next > 0;
            res_rate_reg   <= rate_next;
            res_credit_reg <= credit_next;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.grant       = res_grant_reg;
    assign result.credit_left = res_left_reg;
    assign result.rate_now    = res_rate_reg;
    assign result.credit_now  = res_credit_reg;

    a_refill_only_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        refill_done |-> busy_start)
        else $error("refill finished without a round start in the input register");

    a_start_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_start && !refill_done) |-> !item.ready)
        else $error("new word taken while refill still running");

    // a zero-length packet with zero overhead leaves the credit where it was
    a_grant_spends_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && grant_next) |=> (credit_reg <= $past(credit_reg)))
        else $error("grant raised credit");

    a_rate_held: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && !cfg_we
         && (cmd_reg == CMD_ROUND_START || cmd_reg == CMD_PACKET_OFFER))
        |=> $stable(rate_reg))
        else $error("rate changed on round start or packet offer");

    a_result_from_consume: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(consume))
        else $error("result word appeared without a finished input word");

endmodule

FILE: verif/adaptive_rate_credit_pacer_unit_test.sv
module adaptive_rate_credit_pacer_unit_test;
    import arcp_pkg::*;

    typedef struct {
        arcp_cmd_t             cmd;
        logic [ELAPSED_W-1:0]  elapsed;
        logic [LEN_W-1:0]      packet_length;
        logic                  send_ok;
        logic                  moved;
        logic                  backward;
    } cmd_word_t;

    typedef struct {
        logic                       grant;
        logic                       credit_left;
        logic [RATE_W-1:0]          rate_now;
        logic signed [CREDIT_W-1:0] credit_now;
    } pacer_out_t;

    localparam int  IDLE_LIMIT  = 4000;
    localparam longint CREDIT_TOP = 64'sd2147483647;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    arcp_item_if   item_ch ();
    arcp_result_if result_ch ();

    adaptive_rate_credit_pacer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    // predicted pacer state and registers
    logic [STEP_W-1:0] step_p;
    logic [CAP_W-1:0]  cap_p;
    logic [OVH_W-1:0]  ovh_p;
    logic [RATE_W-1:0] floor_p;
    logic [RATE_W-1:0] rate_p;
    logic [RATE_W-1:0] target_p;
    longint            credit_p;
    logic [15:0]       grants_p;

    cmd_word_t  cmd_pending_q[$];
    pacer_out_t out_expect_q[$];
    cmd_word_t  cur_word;
    pacer_out_t exp_out;
    pacer_out_t pred_out;

    int gap_left;
    int burst_left;
    int rx_tick;
    int rx_mode;
    int idle_cycles;
    int words_in;
    int words_checked;
    int miss_cnt;
    int grant_cnt;
    int rise_cnt;
    int cut_cnt;
    int setting_cnt;

    always #2 clk = ~clk;

    function automatic pacer_out_t pace_word(input cmd_word_t w);
        pacer_out_t        o;
        longint unsigned   span;
        longint unsigned   refill;
        longint unsigned   nxt;
        longint            sum;
        logic [RATE_W-1:0] prev;
        o.grant = 1'b0;
        case (w.cmd)
            CMD_ROUND_START:
            begin
                span = 64'((w.elapsed > 32'(cap_p)) ? 32'(cap_p) : w.elapsed);
                refill = (64'(rate_p) * span) / 1000;
                if (credit_p > 0)
                    credit_p = 0;
                sum = credit_p + longint'(refill);
                credit_p = (sum > CREDIT_TOP) ? CREDIT_TOP : sum;
                grants_p = '0;
            end
            CMD_PACKET_OFFER:
            begin
                if (credit_p > 0)
                begin
                    o.grant = 1'b1;
                    grant_cnt++;
                    credit_p = credit_p - longint'(w.packet_length) - longint'(ovh_p);
                    if (grants_p != 16'hFFFF)
                        grants_p = grants_p + 1'b1;
                end
            end
            CMD_ROUND_END:
            begin
                if (w.send_ok && grants_p != 0 && credit_p <= 0)
                begin
                    nxt = 64'(rate_p) + ((rate_p < target_p) ? 64'(step_p) : 64'(step_p / 2));
                    rate_p = (nxt > 64'hFFFFFF) ? 24'hFFFFFF : nxt[RATE_W-1:0];
                    rise_cnt++;
                end
                grants_p = '0;
            end
            default:
            begin
                if (w.moved)
                begin
                    prev = rate_p;
                    if (w.backward && rate_p > floor_p)
                    begin
                        rate_p = 24'((64'(rate_p) * 95) / 100);
                        cut_cnt++;
                    end
                    target_p = 24'((64'(prev) + 64'(rate_p)) / 2);
                end
            end
        endcase
        o.credit_left = (credit_p > 0);
        o.rate_now = rate_p;
        o.credit_now = credit_p[CREDIT_W-1:0];
        return o;
    endfunction

    function automatic cmd_word_t rand_word();
        cmd_word_t w;
        w.cmd = arcp_cmd_t'($urandom_range(0, 3));
        w.elapsed = $urandom;
        w.packet_length = 16'($urandom);
        w.send_ok = 1'($urandom_range(0, 1));
        w.moved = 1'($urandom_range(0, 1));
        w.backward = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic add_word(input cmd_word_t w);
        cmd_pending_q = {cmd_pending_q, w};
    endtask

    task automatic put(input arcp_cmd_t c, input logic [ELAPSED_W-1:0] el,
                       input logic [LEN_W-1:0] len, input logic ok, input logic mv,
                       input logic bk);
        cmd_word_t w;
        w.cmd = c;
        w.elapsed = el;
        w.packet_length = len;
        w.send_ok = ok;
        w.moved = mv;
        w.backward = bk;
        add_word(w);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (cmd_pending_q.size() != 0 || item_ch.valid || out_expect_q.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_reg(input arcp_reg_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_RATE_STEP:       step_p = val[STEP_W-1:0];
            REG_START_RATE:
            begin
                rate_p = val[RATE_W-1:0];
                target_p = val[RATE_W-1:0];
            end
            REG_ELAPSED_CAP:     cap_p = val[CAP_W-1:0];
            REG_PACKET_OVERHEAD: ovh_p = val[OVH_W-1:0];
            default:             floor_p = val[RATE_W-1:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(input logic [CFG_W-1:0] st, input logic [CFG_W-1:0] sr,
                           input logic [CFG_W-1:0] cp, input logic [CFG_W-1:0] ov,
                           input logic [CFG_W-1:0] fl);
        drain();
        set_reg(REG_RATE_STEP, st);
        set_reg(REG_START_RATE, sr);
        set_reg(REG_ELAPSED_CAP, cp);
        set_reg(REG_PACKET_OVERHEAD, ov);
        set_reg(REG_CUT_FLOOR, fl);
        setting_cnt++;
    endtask

    // mostly whole rounds: start, a few offers, end; the rest repositions and noise
    task automatic gen_rounds(input int n);
        int        made;
        int        r;
        int        k;
        bit        mid_done;
        cmd_word_t w;
        made = 0;
        mid_done = 0;
        while (made < n)
        begin
            if (!mid_done && made >= n / 2)
            begin
                drain();
                mid_done = 1;
            end
            r = $urandom_range(0, 99);
            w = rand_word();
            if (r < 12)
            begin
                add_word(w);
                made++;
            end
            else if (r < 20)
            begin
                w.cmd = CMD_REPOSITION;
                w.moved = ($urandom_range(0, 99) < 85);
                add_word(w);
                made++;
            end
            else
            begin
                w.cmd = CMD_ROUND_START;
                r = $urandom_range(0, 99);
                if (r < 40)
                    w.elapsed = $urandom_range(0, 20);
                else if (r < 65)
                    w.elapsed = $urandom_range(0, 400);
                else if (r < 80)
                    w.elapsed = $urandom_range(0, 30000);
                else if (r < 90)
                    w.elapsed = 32'(cap_p) - 1 + $urandom_range(0, 2);
                add_word(w);
                k = $urandom_range(0, 8);
                repeat (k)
                begin
                    w = rand_word();
                    w.cmd = CMD_PACKET_OFFER;
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        w.packet_length = 16'($urandom_range(0, 2000));
                    else if (r < 90)
                        w.packet_length = 16'($urandom_range(30000, 65535));
                    add_word(w);
                end
                w = rand_word();
                w.cmd = CMD_ROUND_END;
                w.send_ok = ($urandom_range(0, 9) < 8);
                add_word(w);
                made += k + 2;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                pred_out = pace_word(cur_word);
                out_expect_q = {out_expect_q, pred_out};
                words_in++;
            end
            if (item_ch.valid && !item_ch.ready)
            begin
            end
            else if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                item_ch.valid <= 1'b0;
            end
            else if (cmd_pending_q.size() != 0)
            begin
                cur_word = cmd_pending_q.pop_front();
                item_ch.valid <= 1'b1;
                item_ch.command <= cur_word.cmd;
                item_ch.elapsed <= cur_word.elapsed;
                item_ch.packet_length <= cur_word.packet_length;
                item_ch.send_ok <= cur_word.send_ok;
                item_ch.moved <= cur_word.moved;
                item_ch.backward <= cur_word.backward;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                words_checked++;
                if (out_expect_q.size() == 0)
                begin
                    miss_cnt++;
                    if (miss_cnt <= 10)
                        $display("unexpected result word: grant %0b left %0b rate %0d credit %0d",
                                 result_ch.grant, result_ch.credit_left, result_ch.rate_now,
                                 result_ch.credit_now);
                end
                else
                begin
                    exp_out = out_expect_q.pop_front();
                    if (result_ch.grant !== exp_out.grant
                        || result_ch.credit_left !== exp_out.credit_left
                        || result_ch.rate_now !== exp_out.rate_now
                        || result_ch.credit_now !== exp_out.credit_now)
                    begin
                        miss_cnt++;
                        if (miss_cnt <= 10)
                            $display({"word %0d mismatch: exp grant %0b left %0b rate %0d ",
                                      "credit %0d, got grant %0b left %0b rate %0d credit %0d"},
                                     words_checked, exp_out.grant, exp_out.credit_left,
                                     exp_out.rate_now, exp_out.credit_now, result_ch.grant,
                                     result_ch.credit_left, result_ch.rate_now,
                                     result_ch.credit_now);
                    end
                end
            end
            rx_tick++;
            if (rx_tick % 200 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= (rx_tick % 4) != 0;
                2:       result_ch.ready <= 1'($urandom_range(0, 1));
                default: result_ch.ready <= (rx_tick % 5) == 0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("no progress for %0d cycles", IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_RATE_STEP;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.command = CMD_ROUND_START;
        item_ch.elapsed = '0;
        item_ch.packet_length = '0;
        item_ch.send_ok = 1'b0;
        item_ch.moved = 1'b0;
        item_ch.backward = 1'b0;
        result_ch.ready = 1'b0;
        idle_cycles = 0;
        rx_tick = 0;
        rx_mode = 0;
        words_in = 0;
        words_checked = 0;
        miss_cnt = 0;
        grant_cnt = 0;
        rise_cnt = 0;
        cut_cnt = 0;
        setting_cnt = 1;
        step_p = 16'd16;
        rate_p = 24'd20000;
        target_p = 24'd20000;
        cap_p = 20'd20000;
        ovh_p = 10'd100;
        floor_p = 24'd100;
        credit_p = 0;
        grants_p = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: no credit, empty round, still reposition, cap, exhaustion,
        // negative carry, half-step rise at target, cut, positive drop, full step
        put(CMD_PACKET_OFFER, 32'd0, 16'd100, 1'b1, 1'b0, 1'b0);
        put(CMD_ROUND_END, 32'd0, 16'd0, 1'b1, 1'b0, 1'b0);
        put(CMD_REPOSITION, 32'd0, 16'd0, 1'b0, 1'b0, 1'b1);
        put(CMD_ROUND_START, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
        put(CMD_ROUND_START, 32'hFFFFFFFF, 16'd0, 1'b0, 1'b0, 1'b0);
        repeat (7) put(CMD_PACKET_OFFER, 32'd0, 16'hFFFF, 1'b0, 1'b0, 1'b0);
        put(CMD_ROUND_END, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
        put(CMD_ROUND_START, 32'd1, 16'd0, 1'b0, 1'b0, 1'b0);
        put(CMD_PACKET_OFFER, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
        put(CMD_ROUND_START, 32'd3000, 16'd0, 1'b0, 1'b0, 1'b0);
        put(CMD_PACKET_OFFER, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0);
        put(CMD_PACKET_OFFER, 32'd0, 16'd1000, 1'b0, 1'b0, 1'b0);
        put(CMD_ROUND_END, 32'd0, 16'd0, 1'b1, 1'b0, 1'b0);
        put(CMD_ROUND_END, 32'd0, 16'd0, 1'b1, 1'b0, 1'b0);
        put(CMD_REPOSITION, 32'd0, 16'd0, 1'b0, 1'b1, 1'b0);
        put(CMD_REPOSITION, 32'd0, 16'd0, 1'b0, 1'b1, 1'b1);
        put(CMD_ROUND_START, 32'd100, 16'd0, 1'b0, 1'b0, 1'b0);
        put(CMD_ROUND_START, 32'd50, 16'd0, 1'b0, 1'b0, 1'b0);
        put(CMD_PACKET_OFFER, 32'd0, 16'd2000, 1'b0, 1'b0, 1'b0);
        put(CMD_ROUND_END, 32'd0, 16'd0, 1'b1, 1'b0, 1'b0);

        set_all(24'd65535, 24'hFFFFFF, 24'hFFFFF, 24'd1023, 24'd0);
        gen_rounds(200);
        set_all(24'd0, 24'd0, 24'd0, 24'd0, 24'hFFFFFF);
        gen_rounds(100);
        set_all(24'd1, 24'd1, 24'hFFFFF, 24'd0, 24'd0);
        gen_rounds(150);
        repeat (4)
        begin
            set_all(24'($urandom_range(0, 65535)),
                    ($urandom_range(0, 9) < 5) ? 24'($urandom_range(1000, 100000))
                    : ($urandom_range(0, 1) ? 24'($urandom_range(0, 24'hFFFFFF))
                                            : 24'($urandom_range(0, 100))),
                    24'($urandom_range(0, 20'hFFFFF)), 24'($urandom_range(0, 1023)),
                    24'($urandom_range(0, 30000)));
            gen_rounds(220);
        end
        drain();

        $display("covered %0d command words under %0d register settings:",
                 words_in, setting_cnt);
        $display("  %0d grants, %0d rate rises, %0d rate cuts; %0d result words checked",
                 grant_cnt, rise_cnt, cut_cnt, words_checked);
        if (miss_cnt == 0 && out_expect_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
